### sv/rsi_pkg.sv
// Shared widths, constants and sideband types of the ray/sphere intersection pipeline.
`timescale 1ns / 1ps

package rsi_pkg;

    localparam int A_W        = 30;
    localparam int LEN_W      = 31;
    localparam int Q_W        = 31;
    localparam int REM_W      = LEN_W + 1;
    localparam int UNIT_SHIFT = 30;
    localparam int SQ_W       = 33;

    typedef logic signed [31:0] coord_t;

    typedef struct packed {
        coord_t [2:0]              st;
        logic [2:0][A_W-1:0]       an;
        logic [2:0]                neg;
        logic [2:0][30:0]          w;
        logic [62:0]               cst;
        logic [1:0]                s;
        logic                      zero;
    } side1_t;

    typedef struct packed {
        coord_t [2:0]              st;
        logic [2:0]                neg;
        logic [2:0][30:0]          w;
        logic [62:0]               cst;
        logic [1:0]                s;
        logic                      zero;
    } side2_t;

    typedef struct packed {
        coord_t [2:0]              st;
        logic [2:0][31:0]          u;
        logic [33:0]               b;
        logic [1:0]                s;
        logic                      hit;
    } side3_t;

endpackage

### sv/rsi_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband.
`timescale 1ns / 1ps

module rsi_sqrt #(
    parameter int RW = 31,
    parameter int SW = 1
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            ce,
    input  logic            in_valid,
    input  logic [2*RW-1:0] rad,
    input  logic [SW-1:0]   in_side,
    output logic            out_valid,
    output logic [RW-1:0]   root,
    output logic [SW-1:0]   out_side
);

    localparam int RMW = RW + 2;

    logic [RMW-1:0]  rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [2*RW-1:0] rad_reg  [RW];
    logic [SW-1:0]   side_reg [RW];
    logic            vld_reg  [RW];

    genvar g;
    generate
        for (g = 0; g < RW; g++) begin : g_step
            logic [RMW-1:0]  rem_p;
            logic [RW-1:0]   root_p;
            logic [2*RW-1:0] rad_p;
            logic [SW-1:0]   side_p;
            logic            vld_p;
            logic [RMW-1:0]  rem_sh;
            logic [RMW-1:0]  trial;
            logic [RMW-1:0]  rem_next;
            logic            ge;

            if (g == 0) begin : g_first
                assign rem_p  = '0;
                assign root_p = '0;
                assign rad_p  = rad;
                assign side_p = in_side;
                assign vld_p  = in_valid;
            end else begin : g_later
                assign rem_p  = rem_reg[g-1];
                assign root_p = root_reg[g-1];
                assign rad_p  = rad_reg[g-1];
                assign side_p = side_reg[g-1];
                assign vld_p  = vld_reg[g-1];
            end

            always_comb begin
                rem_sh   = {rem_p[RMW-3:0], rad_p[2*RW-1 -: 2]};
                trial    = {root_p, 2'b01};
                ge       = (rem_sh >= trial);
                rem_next = ge ? (rem_sh - trial) : rem_sh;
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[g] <= 1'b0;
                end else if (ce) begin
                    vld_reg[g] <= vld_p;
                end
            end

            always_ff @(posedge aclk) begin
                if (ce) begin
                    rem_reg[g]  <= rem_next;
                    root_reg[g] <= {root_p[RW-2:0], ge};
                    rad_reg[g]  <= {rad_p[2*RW-3:0], 2'b00};
                    side_reg[g] <= side_p;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

### sv/rsi_div.sv
// Pipelined three-lane restoring divider that forms the unit direction components.
`timescale 1ns / 1ps

module rsi_div import rsi_pkg::*; #(
    parameter int SW = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                ce,
    input  logic                in_valid,
    input  logic [2:0][A_W-1:0] num,
    input  logic [LEN_W-1:0]    den,
    input  logic [SW-1:0]       in_side,
    output logic                out_valid,
    output logic [2:0][Q_W-1:0] quo,
    output logic [SW-1:0]       out_side
);

    logic [REM_W-1:0] rem_reg  [Q_W][3];
    logic [Q_W-1:0]   quo_reg  [Q_W][3];
    logic [Q_W-1:0]   bits_reg [Q_W][3];
    logic [LEN_W-1:0] den_reg  [Q_W];
    logic [SW-1:0]    side_reg [Q_W];
    logic             vld_reg  [Q_W];

    genvar g;
    generate
        for (g = 0; g < Q_W; g++) begin : g_step
            logic [REM_W-1:0] rem_p  [3];
            logic [Q_W-1:0]   quo_p  [3];
            logic [Q_W-1:0]   bits_p [3];
            logic [LEN_W-1:0] den_p;
            logic [SW-1:0]    side_p;
            logic             vld_p;
            logic [REM_W-1:0] rem_next [3];
            logic [Q_W-1:0]   quo_next [3];

            if (g == 0) begin : g_first
                always_comb begin
                    for (int i = 0; i < 3; i++) begin
                        rem_p[i]  = REM_W'(num[i][A_W-1:1]);
                        quo_p[i]  = '0;
                        bits_p[i] = {num[i][0], {(Q_W-1){1'b0}}};
                    end
                end
                assign den_p  = den;
                assign side_p = in_side;
                assign vld_p  = in_valid;
            end else begin : g_later
                always_comb begin
                    for (int i = 0; i < 3; i++) begin
                        rem_p[i]  = rem_reg[g-1][i];
                        quo_p[i]  = quo_reg[g-1][i];
                        bits_p[i] = bits_reg[g-1][i];
                    end
                end
                assign den_p  = den_reg[g-1];
                assign side_p = side_reg[g-1];
                assign vld_p  = vld_reg[g-1];
            end

            always_comb begin
                logic [REM_W-1:0] sh;
                logic             ge;
                for (int i = 0; i < 3; i++) begin
                    sh          = {rem_p[i][REM_W-2:0], bits_p[i][Q_W-1]};
                    ge          = (sh >= {1'b0, den_p});
                    rem_next[i] = ge ? (sh - {1'b0, den_p}) : sh;
                    quo_next[i] = {quo_p[i][Q_W-2:0], ge};
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[g] <= 1'b0;
                end else if (ce) begin
                    vld_reg[g] <= vld_p;
                end
            end

            always_ff @(posedge aclk) begin
                if (ce) begin
                    for (int i = 0; i < 3; i++) begin
                        rem_reg[g][i]  <= rem_next[i];
                        quo_reg[g][i]  <= quo_next[i];
                        bits_reg[g][i] <= {bits_p[i][Q_W-2:0], 1'b0};
                    end
                    den_reg[g]  <= den_p;
                    side_reg[g] <= side_p;
                end
            end
        end
    endgenerate

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            quo[i] = quo_reg[Q_W-1][i];
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

### sv/ray_sphere_intersect.sv
// Throughput: one beat per cycle; the whole pipeline holds while a result beat waits.
// The square root and divider are pipelined, one result bit per stage.
// Reset clears all valid bits and sets the center to zero and the radius to 65536.
// Top level of the ray/sphere intersection pipeline with its register port.
`timescale 1ns / 1ps

module ray_sphere_intersect import rsi_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // front_x, front_y, front_z, back_x, back_y, back_z
    output logic [191:0] m_tdata,
    // hit
    output logic         m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_CENTER_Z = 2'd2;
    localparam logic [1:0] REG_RADIUS   = 2'd3;

    function automatic coord_t point(input coord_t st, input logic signed [67:0] pr,
                                     input logic [1:0] s);
        logic signed [40:0] sc;
        logic signed [40:0] sum;
        sc  = 41'(pr >>> UNIT_SHIFT) <<< s;
        sum = 41'(st) + sc;
        if (sum > 41'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (sum < -41'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(sum);
    endfunction

    coord_t      center_reg [3];
    logic [30:0] radius_reg;
    logic        ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            radius_reg    <= 31'd65536;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_CENTER_X: center_reg[0] <= pwdata;
                REG_CENTER_Y: center_reg[1] <= pwdata;
                REG_CENTER_Z: center_reg[2] <= pwdata;
                REG_RADIUS:   radius_reg    <= pwdata[30:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_CENTER_X: prdata = center_reg[0];
            REG_CENTER_Y: prdata = center_reg[1];
            REG_CENTER_Z: prdata = center_reg[2];
            REG_RADIUS:   prdata = {1'b0, radius_reg};
            default:      prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    logic         m_tvalid_reg;
    logic         m_tuser_reg;
    logic [191:0] m_tdata_reg;

    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce;
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    // Front stages: differences, magnitudes, scaling and squares.
    logic               av_reg, bv_reg, cv_reg, dv_reg, ev_reg, fv_reg, gv_reg;
    coord_t             a_st_reg [3];
    logic signed [32:0] a_d_reg  [3];
    logic signed [32:0] a_v_reg  [3];

    coord_t             b_st_reg  [3];
    logic [32:0]        b_md_reg  [3];
    logic [32:0]        b_mv_reg  [3];
    logic signed [32:0] b_v_reg   [3];
    logic [2:0]         b_neg_reg;
    logic               b_zero_reg;

    coord_t             c_st_reg [3];
    logic [32:0]        c_a_reg  [3];
    logic signed [32:0] c_v_reg  [3];
    logic [32:0]        c_amax_reg;
    logic [1:0]         c_s_reg;
    logic [2:0]         c_neg_reg;
    logic               c_zero_reg;

    coord_t             d_st_reg [3];
    logic [32:0]        d_a_reg  [3];
    logic signed [30:0] d_w_reg  [3];
    logic [29:0]        d_rs_reg;
    logic [5:0]         d_p_reg;
    logic [1:0]         d_s_reg;
    logic [2:0]         d_neg_reg;
    logic               d_zero_reg;

    coord_t             e_st_reg [3];
    logic [A_W-1:0]     e_an_reg [3];
    logic signed [30:0] e_w_reg  [3];
    logic signed [61:0] e_w2_reg [3];
    logic [59:0]        e_rs2_reg;
    logic [1:0]         e_s_reg;
    logic [2:0]         e_neg_reg;
    logic               e_zero_reg;

    coord_t             f_st_reg  [3];
    logic [A_W-1:0]     f_an_reg  [3];
    logic signed [30:0] f_w_reg   [3];
    logic [59:0]        f_asq_reg [3];
    logic signed [62:0] f_cst_reg;
    logic [1:0]         f_s_reg;
    logic [2:0]         f_neg_reg;
    logic               f_zero_reg;

    logic [61:0]        g_s2_reg;
    side1_t             g_side_reg;

    logic [32:0] c_amax_next;
    logic [32:0] c_m2;
    logic [1:0]  c_s_next;
    logic [5:0]  d_p_next;

    always_comb begin
        c_amax_next = b_md_reg[0];
        if (b_md_reg[1] > c_amax_next) c_amax_next = b_md_reg[1];
        if (b_md_reg[2] > c_amax_next) c_amax_next = b_md_reg[2];
        c_m2 = {2'b00, radius_reg};
        for (int i = 0; i < 3; i++) begin
            if (b_mv_reg[i] > c_m2) c_m2 = b_mv_reg[i];
        end
        if (c_m2[32]) begin
            c_s_next = 2'd3;
        end else if (c_m2[31]) begin
            c_s_next = 2'd2;
        end else if (c_m2[30]) begin
            c_s_next = 2'd1;
        end else begin
            c_s_next = 2'd0;
        end
        d_p_next = '0;
        for (int i = 0; i < 33; i++) begin
            if (c_amax_reg[i]) d_p_next = 6'(i);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            av_reg <= 1'b0;
            bv_reg <= 1'b0;
            cv_reg <= 1'b0;
            dv_reg <= 1'b0;
            ev_reg <= 1'b0;
            fv_reg <= 1'b0;
            gv_reg <= 1'b0;
        end else if (ce) begin
            av_reg <= s_tvalid;
            bv_reg <= av_reg;
            cv_reg <= bv_reg;
            dv_reg <= cv_reg;
            ev_reg <= dv_reg;
            fv_reg <= ev_reg;
            gv_reg <= fv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                a_st_reg[i] <= s_tdata[32*i +: 32];
                a_d_reg[i]  <= 33'($signed(s_tdata[96+32*i +: 32]))
                             - 33'($signed(s_tdata[32*i +: 32]));
                a_v_reg[i]  <= 33'($signed(s_tdata[32*i +: 32])) - 33'(center_reg[i]);

                b_st_reg[i] <= a_st_reg[i];
                b_md_reg[i] <= a_d_reg[i][32] ? 33'(-a_d_reg[i]) : 33'(a_d_reg[i]);
                b_mv_reg[i] <= a_v_reg[i][32] ? 33'(-a_v_reg[i]) : 33'(a_v_reg[i]);
                b_v_reg[i]  <= a_v_reg[i];
                b_neg_reg[i] <= a_d_reg[i][32];

                c_st_reg[i] <= b_st_reg[i];
                c_a_reg[i]  <= b_md_reg[i];
                c_v_reg[i]  <= b_v_reg[i];

                d_st_reg[i] <= c_st_reg[i];
                d_a_reg[i]  <= c_a_reg[i];
                d_w_reg[i]  <= 31'(c_v_reg[i] >>> c_s_reg);

                e_st_reg[i] <= d_st_reg[i];
                if (d_p_reg >= 6'd29) begin
                    e_an_reg[i] <= A_W'(d_a_reg[i] >> (d_p_reg - 6'd29));
                end else begin
                    e_an_reg[i] <= A_W'(62'(d_a_reg[i]) << (6'd29 - d_p_reg));
                end
                e_w_reg[i]  <= d_w_reg[i];
                e_w2_reg[i] <= 62'(d_w_reg[i]) * 62'(d_w_reg[i]);

                f_st_reg[i]  <= e_st_reg[i];
                f_an_reg[i]  <= e_an_reg[i];
                f_w_reg[i]   <= e_w_reg[i];
                f_asq_reg[i] <= 60'(e_an_reg[i]) * 60'(e_an_reg[i]);

                g_side_reg.st[i] <= f_st_reg[i];
                g_side_reg.an[i] <= f_an_reg[i];
                g_side_reg.w[i]  <= f_w_reg[i];
            end
            b_zero_reg <= (a_d_reg[0] == '0) && (a_d_reg[1] == '0) && (a_d_reg[2] == '0);

            c_amax_reg <= c_amax_next;
            c_s_reg    <= c_s_next;
            c_neg_reg  <= b_neg_reg;
            c_zero_reg <= b_zero_reg;

            d_p_reg    <= d_p_next;
            d_rs_reg   <= 30'(radius_reg >> c_s_reg);
            d_s_reg    <= c_s_reg;
            d_neg_reg  <= c_neg_reg;
            d_zero_reg <= c_zero_reg;

            e_rs2_reg  <= 60'(d_rs_reg) * 60'(d_rs_reg);
            e_s_reg    <= d_s_reg;
            e_neg_reg  <= d_neg_reg;
            e_zero_reg <= d_zero_reg;

            f_cst_reg  <= $signed(63'(e_rs2_reg))
                        - (63'(e_w2_reg[0]) + 63'(e_w2_reg[1]) + 63'(e_w2_reg[2]));
            f_s_reg    <= e_s_reg;
            f_neg_reg  <= e_neg_reg;
            f_zero_reg <= e_zero_reg;

            g_s2_reg        <= 62'(f_asq_reg[0]) + 62'(f_asq_reg[1]) + 62'(f_asq_reg[2]);
            g_side_reg.neg  <= f_neg_reg;
            g_side_reg.cst  <= f_cst_reg;
            g_side_reg.s    <= f_s_reg;
            g_side_reg.zero <= f_zero_reg;
        end
    end

    // Line length.
    logic                 len_valid;
    logic [LEN_W-1:0]     len;
    logic [$bits(side1_t)-1:0] len_side_raw;
    side1_t               len_side;

    rsi_sqrt #(
        .RW (LEN_W),
        .SW ($bits(side1_t))
    ) u_len_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (gv_reg),
        .rad       (g_s2_reg),
        .in_side   (g_side_reg),
        .out_valid (len_valid),
        .root      (len),
        .out_side  (len_side_raw)
    );

    assign len_side = side1_t'(len_side_raw);

    // Unit direction.
    side2_t               div_side_in;
    logic                 div_valid;
    logic [2:0][Q_W-1:0]  div_quo;
    logic [$bits(side2_t)-1:0] div_side_raw;
    side2_t               div_side;

    always_comb begin
        div_side_in.st   = len_side.st;
        div_side_in.neg  = len_side.neg;
        div_side_in.w    = len_side.w;
        div_side_in.cst  = len_side.cst;
        div_side_in.s    = len_side.s;
        div_side_in.zero = len_side.zero;
    end

    rsi_div #(
        .SW ($bits(side2_t))
    ) u_dir_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (len_valid),
        .num       (len_side.an),
        .den       (len),
        .in_side   (div_side_in),
        .out_valid (div_valid),
        .quo       (div_quo),
        .out_side  (div_side_raw)
    );

    assign div_side = side2_t'(div_side_raw);

    // Quadratic terms and discriminant.
    logic               p1v_reg, p2v_reg, p3v_reg, p4v_reg, p5v_reg;
    logic signed [31:0] p1_u_reg [3];
    side2_t             p1_side_reg;
    logic signed [31:0] p2_u_reg [3];
    logic signed [62:0] p2_uw_reg [3];
    side2_t             p2_side_reg;
    logic signed [31:0] p3_u_reg [3];
    logic signed [33:0] p3_b_reg;
    side2_t             p3_side_reg;
    logic signed [31:0] p4_u_reg [3];
    logic signed [33:0] p4_b_reg;
    logic signed [67:0] p4_bb_reg;
    side2_t             p4_side_reg;
    logic [65:0]        p5_disc_reg;
    side3_t             p5_side_reg;

    logic signed [64:0] p3_dot;
    logic signed [68:0] p5_disc;

    always_comb begin
        p3_dot  = 65'(p2_uw_reg[0]) + 65'(p2_uw_reg[1]) + 65'(p2_uw_reg[2]);
        p5_disc = 69'(p4_bb_reg) + 69'($signed(p4_side_reg.cst));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1v_reg <= 1'b0;
            p2v_reg <= 1'b0;
            p3v_reg <= 1'b0;
            p4v_reg <= 1'b0;
            p5v_reg <= 1'b0;
        end else if (ce) begin
            p1v_reg <= div_valid;
            p2v_reg <= p1v_reg;
            p3v_reg <= p2v_reg;
            p4v_reg <= p3v_reg;
            p5v_reg <= p4v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                p1_u_reg[i]  <= div_side.neg[i] ? -$signed({1'b0, div_quo[i]})
                                                :  $signed({1'b0, div_quo[i]});
                p2_u_reg[i]  <= p1_u_reg[i];
                p2_uw_reg[i] <= 63'(p1_u_reg[i]) * 63'($signed(p1_side_reg.w[i]));
                p3_u_reg[i]  <= p2_u_reg[i];
                p4_u_reg[i]  <= p3_u_reg[i];
                p5_side_reg.st[i] <= p4_side_reg.st[i];
                p5_side_reg.u[i]  <= p4_u_reg[i];
            end
            p1_side_reg <= div_side;
            p2_side_reg <= p1_side_reg;
            p3_b_reg    <= 34'(p3_dot >>> UNIT_SHIFT);
            p3_side_reg <= p2_side_reg;
            p4_b_reg    <= p3_b_reg;
            p4_bb_reg   <= 68'(p3_b_reg) * 68'(p3_b_reg);
            p4_side_reg <= p3_side_reg;
            p5_disc_reg <= p5_disc[68] ? '0 : 66'(p5_disc);
            p5_side_reg.b   <= p4_b_reg;
            p5_side_reg.s   <= p4_side_reg.s;
            p5_side_reg.hit <= !p4_side_reg.zero && !p5_disc[68];
        end
    end

    // Root of the discriminant.
    logic                 sq_valid;
    logic [SQ_W-1:0]      sq;
    logic [$bits(side3_t)-1:0] sq_side_raw;
    side3_t               sq_side;

    rsi_sqrt #(
        .RW (SQ_W),
        .SW ($bits(side3_t))
    ) u_disc_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (p5v_reg),
        .rad       (p5_disc_reg),
        .in_side   (p5_side_reg),
        .out_valid (sq_valid),
        .root      (sq),
        .out_side  (sq_side_raw)
    );

    assign sq_side = side3_t'(sq_side_raw);

    // Roots and intersection points.
    logic               q1v_reg, q2v_reg;
    logic signed [35:0] q1_t0_reg, q1_t1_reg;
    side3_t             q1_side_reg;
    logic signed [67:0] q2_pr0_reg [3];
    logic signed [67:0] q2_pr1_reg [3];
    coord_t             q2_st_reg  [3];
    logic [1:0]         q2_s_reg;
    logic               q2_hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q1v_reg      <= 1'b0;
            q2v_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            q1v_reg      <= sq_valid;
            q2v_reg      <= q1v_reg;
            m_tvalid_reg <= q2v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            q1_t0_reg   <= -36'($signed(sq_side.b)) - $signed({3'b000, sq});
            q1_t1_reg   <= -36'($signed(sq_side.b)) + $signed({3'b000, sq});
            q1_side_reg <= sq_side;
            for (int i = 0; i < 3; i++) begin
                q2_pr0_reg[i] <= 68'($signed(q1_side_reg.u[i])) * 68'(q1_t0_reg);
                q2_pr1_reg[i] <= 68'($signed(q1_side_reg.u[i])) * 68'(q1_t1_reg);
                q2_st_reg[i]  <= q1_side_reg.st[i];
                if (q2_hit_reg) begin
                    m_tdata_reg[32*i +: 32]    <= point(q2_st_reg[i], q2_pr0_reg[i], q2_s_reg);
                    m_tdata_reg[96+32*i +: 32] <= point(q2_st_reg[i], q2_pr1_reg[i], q2_s_reg);
                end else begin
                    m_tdata_reg[32*i +: 32]    <= '0;
                    m_tdata_reg[96+32*i +: 32] <= '0;
                end
            end
            q2_s_reg    <= q1_side_reg.s;
            q2_hit_reg  <= q1_side_reg.hit;
            m_tuser_reg <= q2_hit_reg;
        end
    end

endmodule

### sv/rsi_checker.sv
// Port-level checks on the intersection pipeline, bound to the top level.
`timescale 1ns / 1ps

module rsi_port_checks (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [191:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata,
    input logic         m_tuser,
    input logic         psel,
    input logic         penable,
    input logic         pwrite,
    input logic [3:0]   paddr,
    input logic [31:0]  pwdata,
    input logic [31:0]  prdata,
    input logic         pready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("miss beat carries nonzero points");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

    a_stall_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow the output stall");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("register port not ready");

endmodule

bind ray_sphere_intersect rsi_port_checks u_rsi_port_checks (.*);
